// ===== src/fatlb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fatlb_pkg
// Shared types and constants of the fully associative translation buffer.
// ----------------------------------------------------------------------------
package fatlb_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int PAGE_BITS_DEF  = 20;
  localparam int FRAME_BITS_DEF = 20;

  localparam int          CAP_W     = 5;
  localparam int          FRAME_O_W = 20;
  localparam logic [4:0]  CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_FLUSH  = 2'd3
  } fatlb_mode_e;

  typedef struct packed {
    logic                 hit;
    logic [FRAME_O_W-1:0] frame_out;
    logic                 evicted;
  } fatlb_result_t;

endpackage

// ===== src/fatlb_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fatlb_in_reg
// Input register: captures one item and holds it until the array takes it.
// ----------------------------------------------------------------------------
module fatlb_in_reg import fatlb_pkg::*; #(
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            mode_i,
  input  logic [PAGE_BITS-1:0]  page_number_i,
  input  logic [FRAME_BITS-1:0] frame_number_i,
  input  logic                  perm_read_i,
  input  logic                  perm_write_i,
  input  logic                  perm_execute_i,
  input  logic                  take_i,
  output logic                  valid_o,
  output fatlb_mode_e           mode_o,
  output logic [PAGE_BITS-1:0]  page_o,
  output logic [FRAME_BITS-1:0] frame_o,
  output logic [2:0]            perms_o
);

  logic                  valid_q;
  fatlb_mode_e           mode_q;
  logic [PAGE_BITS-1:0]  page_q;
  logic [FRAME_BITS-1:0] frame_q;
  logic [2:0]            perms_q;
  logic                  load;

  // hold while an item sits here that the array cannot take
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q  <= fatlb_mode_e'(mode_i);
      page_q  <= page_number_i;
      frame_q <= frame_number_i;
      perms_q <= {perm_read_i, perm_write_i, perm_execute_i};
    end
  end

  assign valid_o = valid_q;
  assign mode_o  = mode_q;
  assign page_o  = page_q;
  assign frame_o = frame_q;
  assign perms_o = perms_q;

endmodule

// ===== src/fatlb_array.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fatlb_array
// Entry storage with parallel tag compare and rank based LRU replacement.
// ----------------------------------------------------------------------------
module fatlb_array import fatlb_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  fatlb_mode_e           mode_i,
  input  logic [PAGE_BITS-1:0]  page_i,
  input  logic [FRAME_BITS-1:0] frame_i,
  input  logic [2:0]            perms_i,
  input  logic [CAP_W-1:0]      capacity_i,
  output fatlb_result_t         result_o
);

  localparam int RW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [RW-1:0]         rank_q [ENTRIES];
  logic [RW-1:0]         rank_d [ENTRIES];
  logic [PAGE_BITS-1:0]  page_q [ENTRIES];
  logic [FRAME_BITS-1:0] frame_q [ENTRIES];
  logic [2:0]            perm_q [ENTRIES];
  logic [CW-1:0]         count_q, count_d;

  logic [ENTRIES-1:0]    match, lru, free_vec, free_first, ins_slot, wr_slot;
  logic                  hit_any, evict;
  logic [RW-1:0]         hit_rank, lru_rank;
  logic [FRAME_BITS-1:0] hit_frame;
  logic [FRAME_O_W-1:0]  hit_frame_o;
  logic [XW-1:0]         cap_x, cap_eff, count_x;

  // effective capacity: zero acts as one, saturate at the table size
  always_comb begin
    cap_x   = XW'(capacity_i);
    count_x = XW'(count_q);
    if (cap_x == '0) begin
      cap_eff = XW'(1);
    end else if (cap_x > XW'(ENTRIES)) begin
      cap_eff = XW'(ENTRIES);
    end else begin
      cap_eff = cap_x;
    end
  end

  // valid ranks are distinct 0..count-1, so the LRU entry holds count-1
  assign lru_rank = RW'(count_q - 1'b1);

  always_comb begin
    hit_rank  = '0;
    hit_frame = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (page_q[i] == page_i);
      lru[i]   = valid_q[i] && (rank_q[i] == lru_rank);
      hit_rank  = hit_rank  | (match[i] ? rank_q[i]  : '0);
      hit_frame = hit_frame | (match[i] ? frame_q[i] : '0);
    end
  end

  assign hit_any    = |match;
  assign free_vec   = ~valid_q;
  assign free_first = free_vec & (~free_vec + 1'b1);
  assign evict      = !hit_any && (count_x >= cap_eff);
  assign ins_slot   = evict ? lru : free_first;
  assign wr_slot    = hit_any ? match : ins_slot;

  generate
    if (FRAME_BITS >= FRAME_O_W) begin : g_frame_trunc
      assign hit_frame_o = hit_frame[FRAME_O_W-1:0];
    end else begin : g_frame_ext
      assign hit_frame_o = {{(FRAME_O_W-FRAME_BITS){1'b0}}, hit_frame};
    end
  endgenerate

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    count_d = count_q;
    unique case (mode_i) inside
      MODE_LOOKUP, MODE_UPDATE: begin
        if (hit_any) begin
          // promote the hit entry, age those that were more recent
          for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
              rank_d[i] = '0;
            end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
              rank_d[i] = rank_q[i] + 1'b1;
            end
          end
        end else if (mode_i == MODE_UPDATE) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (ins_slot[i]) begin
              valid_d[i] = 1'b1;
              rank_d[i]  = '0;
            end else if (valid_q[i]) begin
              rank_d[i] = rank_q[i] + 1'b1;
            end
          end
          if (!evict) begin
            count_d = count_q + 1'b1;
          end
        end
      end
      MODE_DELETE: begin
        if (hit_any) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
              valid_d[i] = 1'b0;
              rank_d[i]  = '0;
            end else if (valid_q[i] && (rank_q[i] > hit_rank)) begin
              rank_d[i] = rank_q[i] - 1'b1;
            end
          end
          count_d = count_q - 1'b1;
        end
      end
      MODE_FLUSH: begin
        valid_d = '0;
        count_d = '0;
        for (int i = 0; i < ENTRIES; i++) begin
          rank_d[i] = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (en_i) begin
      valid_q <= valid_d;
      count_q <= count_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && (mode_i == MODE_UPDATE)) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (wr_slot[i]) begin
          frame_q[i] <= frame_i;
          perm_q[i]  <= perms_i;
          if (!hit_any) begin
            page_q[i] <= page_i;
          end
        end
      end
    end
  end

  always_comb begin
    result_o.hit       = (mode_i == MODE_LOOKUP) && hit_any;
    result_o.frame_out = result_o.hit ? hit_frame_o : '0;
    result_o.evicted   = (mode_i == MODE_UPDATE) && evict;
  end

endmodule

// ===== src/fully_associative_tlb_lru.sv =====
`timescale 1ns / 1ps
// Pipeline: an accepted item sits in the input register, and its result is
// registered in the result register (tag compare and LRU update between). Throughput:
// one item per cycle while out_stall_i does not hold a full result register; the entry
// state is updated at the same edge that registers the result, so the next item sees it.
// Reset: all entries invalid, ranks zero, capacity 16; no clearing pass.
// ----------------------------------------------------------------------------
// fully_associative_tlb_lru
// Fully associative translation buffer with least-recently-used replacement.
// ----------------------------------------------------------------------------
module fully_associative_tlb_lru import fatlb_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CAP_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            mode_i,
  input  logic [PAGE_BITS-1:0]  page_number_i,
  input  logic [FRAME_BITS-1:0] frame_number_i,
  input  logic                  perm_read_i,
  input  logic                  perm_write_i,
  input  logic                  perm_execute_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output logic [FRAME_O_W-1:0]  frame_out_o,
  output logic                  evicted_o
);

  logic [CAP_W-1:0]      cap_q;
  logic                  op_valid, advance;
  fatlb_mode_e           op_mode;
  logic [PAGE_BITS-1:0]  op_page;
  logic [FRAME_BITS-1:0] op_frame;
  logic [2:0]            op_perms;
  fatlb_result_t         result, result_q;
  logic                  out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // advance when the result register is free or drains this cycle
  assign advance = op_valid && (!out_valid_q || !out_stall_i);

  fatlb_in_reg #(
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_in_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .page_number_i  (page_number_i),
    .frame_number_i (frame_number_i),
    .perm_read_i    (perm_read_i),
    .perm_write_i   (perm_write_i),
    .perm_execute_i (perm_execute_i),
    .take_i         (advance),
    .valid_o        (op_valid),
    .mode_o         (op_mode),
    .page_o         (op_page),
    .frame_o        (op_frame),
    .perms_o        (op_perms)
  );

  fatlb_array #(
    .ENTRIES    (ENTRIES),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_array (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .mode_i     (op_mode),
    .page_i     (op_page),
    .frame_i    (op_frame),
    .perms_i    (op_perms),
    .capacity_i (cap_q),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = result_q.hit;
  assign frame_out_o = result_q.frame_out;
  assign evicted_o   = result_q.evicted;

endmodule
